@@ sv/tpq_pkg.sv @@
// Shared types, codes and constants of the two-level priority event queue.
package tpq_pkg;

   localparam int DEF_HI_DEPTH  = 16;
   localparam int DEF_LOW_DEPTH = 16;

   localparam int NODE_W    = 16;
   localparam int ETYPE_W   = 3;
   localparam int IDENT_W   = 16;
   localparam int QUEUE_W   = 16;
   localparam int PAYLOAD_W = 64;
   localparam int REQ_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int FILL_W    = 4;
   localparam int TOTAL_W   = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_QNUM = 1'b0;

   localparam logic [REQ_W-1:0] REQ_SEND  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
   localparam logic [REQ_W-1:0] REQ_STATS = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STS_BAD   = 2'd3;

   localparam logic [ETYPE_W-1:0] ETYPE_MAX = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
      logic rd;
   } ring_cmd_type;

   typedef struct packed {
      logic [NODE_W-1:0]    node;
      logic [ETYPE_W-1:0]   etype;
      logic                 owned;
      logic [IDENT_W-1:0]   ident;
      logic [QUEUE_W-1:0]   queue;
      logic [PAYLOAD_W-1:0] payload;
   } ev_item_type;

   localparam int EVENT_W = $bits(ev_item_type);

   typedef struct packed {
      logic [REQ_W-1:0]     req_type;
      logic                 priority_req;
      logic [NODE_W-1:0]    node_id;
      logic [ETYPE_W-1:0]   etype;
      logic                 owned;
      logic [IDENT_W-1:0]   ident;
      logic [PAYLOAD_W-1:0] payload;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      ev_item_type         ev;
      logic [FILL_W-1:0]   high_fill;
      logic [FILL_W-1:0]   low_fill;
      logic [FILL_W-1:0]   high_peak;
      logic [TOTAL_W-1:0]  total_peak;
   } rsp_item_type;

endpackage

@@ sv/tpq_if.sv @@
// Request and response channel interfaces of the event queue.
interface tpq_req_if import tpq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic                 priority_req;
   logic [NODE_W-1:0]    node_id;
   logic [ETYPE_W-1:0]   etype;
   logic                 owned;
   logic [IDENT_W-1:0]   ident;
   logic [PAYLOAD_W-1:0] payload;

   modport source (
      output valid, req_type, priority_req, node_id, etype, owned, ident, payload,
      input  ready
   );
   modport sink (
      input  valid, req_type, priority_req, node_id, etype, owned, ident, payload,
      output ready
   );
endinterface

interface tpq_rsp_if import tpq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [NODE_W-1:0]    ev_node;
   logic [ETYPE_W-1:0]   ev_type;
   logic                 ev_owned;
   logic [IDENT_W-1:0]   ev_ident;
   logic [QUEUE_W-1:0]   ev_queue;
   logic [PAYLOAD_W-1:0] ev_payload;
   logic [FILL_W-1:0]    high_fill;
   logic [FILL_W-1:0]    low_fill;
   logic [FILL_W-1:0]    high_peak;
   logic [TOTAL_W-1:0]   total_peak;

   modport source (
      output valid, status, ev_node, ev_type, ev_owned, ev_ident, ev_queue,
             ev_payload, high_fill, low_fill, high_peak, total_peak,
      input  ready
   );
   modport sink (
      input  valid, status, ev_node, ev_type, ev_owned, ev_ident, ev_queue,
             ev_payload, high_fill, low_fill, high_peak, total_peak,
      output ready
   );
endinterface

@@ sv/tpq_ring.sv @@
// Ring FIFO of events: RAM with registered read, head and tail pointers.
module tpq_ring import tpq_pkg::*; #(
   parameter int DEPTH = DEF_HI_DEPTH,
   parameter int W     = EVENT_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ring_cmd_type             cmd,
   input  logic [W-1:0]             wdata,
   output logic [W-1:0]             rdata,
   output logic [$clog2(DEPTH)-1:0] count,
   output logic                     full,
   output logic                     empty
);

   localparam int AW = $clog2(DEPTH);

   logic [W-1:0]  mem [DEPTH];
   logic [W-1:0]  rdata_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (cmd.clear) begin
         head_in = '0;
         tail_in = '0;
      end else begin
         if (cmd.push) head_in = head_ff + AW'(1);
         if (cmd.pop)  tail_in = tail_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) mem[head_ff] <= wdata;
      if (cmd.rd)   rdata_ff <= mem[tail_ff];
   end

   assign rdata = rdata_ff;
   assign count = head_ff - tail_ff;
   assign full  = (head_ff + AW'(1)) == tail_ff;
   assign empty = head_ff == tail_ff;

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !full) else $error("push into full ring");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !empty) else $error("pop from empty ring");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> empty) else $error("ring not empty after clear");

endmodule

@@ sv/tpq_ctrl.sv @@
// Controller: sequences capture, execute and response of one transaction.
module tpq_ctrl import tpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

@@ sv/tpq_datapath.sv @@
// Datapath: request register, both rings, high-water marks and queue number.
module tpq_datapath import tpq_pkg::*; #(
   parameter int HI_DEPTH  = DEF_HI_DEPTH,
   parameter int LOW_DEPTH = DEF_LOW_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   input  req_item_type       req,
   input  logic               cfg_we,
   input  logic [QUEUE_W-1:0] cfg_wdata,
   output logic [QUEUE_W-1:0] qnum,
   output rsp_item_type       rsp
);

   localparam int HAW = $clog2(HI_DEPTH);
   localparam int LAW = $clog2(LOW_DEPTH);
   localparam int TW  = $clog2(HI_DEPTH + LOW_DEPTH);

   req_item_type        req_ff;
   logic [QUEUE_W-1:0]  qnum_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                ev_valid_ff, ev_valid_in;
   logic                sel_high_ff, sel_high_in;
   logic [HAW-1:0]      high_mark_ff, high_mark_in;
   logic [TW-1:0]       total_mark_ff, total_mark_in;

   ring_cmd_type        hi_cmd, lo_cmd;
   logic [EVENT_W-1:0]  hi_rdata, lo_rdata;
   logic [HAW-1:0]      hi_count, hi_post;
   logic [LAW-1:0]      lo_count, lo_post;
   logic [TW-1:0]       total_post;
   logic                hi_full, hi_empty, lo_full, lo_empty;
   ev_item_type         wr_event, rd_event;

   assign wr_event = '{node:    req_ff.node_id,
                       etype:   req_ff.etype,
                       owned:   req_ff.owned,
                       ident:   req_ff.ident,
                       queue:   qnum_ff,
                       payload: req_ff.payload};

   always_comb begin
      hi_cmd      = '0;
      lo_cmd      = '0;
      status_in   = status_ff;
      ev_valid_in = ev_valid_ff;
      sel_high_in = sel_high_ff;
      if (cmd.exec) begin
         status_in   = STS_OK;
         ev_valid_in = 1'b0;
         unique case (req_ff.req_type) inside
            REQ_SEND: begin
               if (req_ff.etype > ETYPE_MAX) begin
                  status_in = STS_BAD;
               end else if (req_ff.priority_req) begin
                  if (hi_full) status_in = STS_FULL;
                  else         hi_cmd.push = 1'b1;
               end else begin
                  if (lo_full) status_in = STS_FULL;
                  else         lo_cmd.push = 1'b1;
               end
            end
            REQ_POP, REQ_PEEK: begin
               if (!hi_empty) begin
                  hi_cmd.rd   = 1'b1;
                  hi_cmd.pop  = req_ff.req_type == REQ_POP;
                  sel_high_in = 1'b1;
                  ev_valid_in = 1'b1;
               end else if (!lo_empty) begin
                  lo_cmd.rd   = 1'b1;
                  lo_cmd.pop  = req_ff.req_type == REQ_POP;
                  sel_high_in = 1'b0;
                  ev_valid_in = 1'b1;
               end else begin
                  status_in = STS_EMPTY;
               end
            end
            REQ_CLEAR: begin
               hi_cmd.clear = 1'b1;
               lo_cmd.clear = 1'b1;
            end
            default: status_in = STS_OK;
         endcase
      end
   end

   // fills as they stand after a send, marks rise only on an accepted send
   assign hi_post    = hi_count + HAW'(hi_cmd.push);
   assign lo_post    = lo_count + LAW'(lo_cmd.push);
   assign total_post = TW'(hi_post) + TW'(lo_post);

   always_comb begin
      high_mark_in  = high_mark_ff;
      total_mark_in = total_mark_ff;
      if (cmd.exec && req_ff.req_type == REQ_STATS) begin
         high_mark_in  = '0;
         total_mark_in = '0;
      end else if (hi_cmd.push || lo_cmd.push) begin
         if (hi_post > high_mark_ff)     high_mark_in  = hi_post;
         if (total_post > total_mark_ff) total_mark_in = total_post;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qnum_ff       <= '0;
         high_mark_ff  <= '0;
         total_mark_ff <= '0;
         ev_valid_ff   <= 1'b0;
      end else begin
         if (cfg_we) qnum_ff <= cfg_wdata;
         high_mark_ff  <= high_mark_in;
         total_mark_ff <= total_mark_in;
         ev_valid_ff   <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      status_ff   <= status_in;
      sel_high_ff <= sel_high_in;
   end

   tpq_ring #(.DEPTH(HI_DEPTH), .W(EVENT_W)) u_high (
      .clock (clock),
      .reset (reset),
      .cmd   (hi_cmd),
      .wdata (wr_event),
      .rdata (hi_rdata),
      .count (hi_count),
      .full  (hi_full),
      .empty (hi_empty)
   );

   tpq_ring #(.DEPTH(LOW_DEPTH), .W(EVENT_W)) u_low (
      .clock (clock),
      .reset (reset),
      .cmd   (lo_cmd),
      .wdata (wr_event),
      .rdata (lo_rdata),
      .count (lo_count),
      .full  (lo_full),
      .empty (lo_empty)
   );

   assign rd_event = sel_high_ff ? ev_item_type'(hi_rdata) : ev_item_type'(lo_rdata);

   assign qnum           = qnum_ff;
   assign rsp.status     = status_ff;
   assign rsp.ev         = ev_valid_ff ? rd_event : '0;
   assign rsp.high_fill  = FILL_W'(hi_count);
   assign rsp.low_fill   = FILL_W'(lo_count);
   assign rsp.high_peak  = FILL_W'(high_mark_ff);
   assign rsp.total_peak = TOTAL_W'(total_mark_ff);

endmodule

@@ sv/two_level_priority_event_queue.sv @@
// Two-level priority event queue: top level with channels and CSR port.
//
// Requests arrive on req_chan (send, pop, peek, clear, stats reset); each
// accepted transaction yields exactly one response on rsp_chan carrying the
// status, the popped or peeked event (zero otherwise), both ring fills and
// the high-water marks. Sends go to the high or low ring by priority_req and
// are stamped with the queue number written over the CSR port at offset 0.
// A ring of depth D holds D-1 events; pop and peek serve the high ring first.
// Each request is captured, then executed (ring RAM write or registered
// RAM read, pointer update), then answered with a registered response.
// One transaction is in flight at a time, so a new request is taken only
// after the last response has been taken. While the receiver holds
// rsp_chan.ready low the response stays put and req_chan.ready stays low.
// Reset clears ring pointers, high-water marks and the queue number; ring
// RAM contents are not cleared and are only read behind a valid entry.
module two_level_priority_event_queue import tpq_pkg::*; #(
   parameter int HI_DEPTH  = DEF_HI_DEPTH,
   parameter int LOW_DEPTH = DEF_LOW_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   tpq_req_if.sink               req_chan,
   tpq_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   ctrl_cmd_type       cmd;
   req_item_type       req;
   rsp_item_type       rsp;
   logic [QUEUE_W-1:0] qnum;
   logic               cfg_we;
   logic               sel_qnum;

   assign req = '{req_type:     req_chan.req_type,
                  priority_req: req_chan.priority_req,
                  node_id:      req_chan.node_id,
                  etype:        req_chan.etype,
                  owned:        req_chan.owned,
                  ident:        req_chan.ident,
                  payload:      req_chan.payload};

   assign sel_qnum   = csr_paddr[CSR_ADDR_W-1] == CSR_IDX_QNUM;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && sel_qnum;
   assign csr_pready = 1'b1;
   assign csr_prdata = sel_qnum ? CSR_DATA_W'(qnum) : '0;

   tpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   tpq_datapath #(.HI_DEPTH(HI_DEPTH), .LOW_DEPTH(LOW_DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req),
      .cfg_we    (cfg_we),
      .cfg_wdata (csr_pwdata[QUEUE_W-1:0]),
      .qnum      (qnum),
      .rsp       (rsp)
   );

   assign rsp_chan.status     = rsp.status;
   assign rsp_chan.ev_node    = rsp.ev.node;
   assign rsp_chan.ev_type    = rsp.ev.etype;
   assign rsp_chan.ev_owned   = rsp.ev.owned;
   assign rsp_chan.ev_ident   = rsp.ev.ident;
   assign rsp_chan.ev_queue   = rsp.ev.queue;
   assign rsp_chan.ev_payload = rsp.ev.payload;
   assign rsp_chan.high_fill  = rsp.high_fill;
   assign rsp_chan.low_fill   = rsp.low_fill;
   assign rsp_chan.high_peak  = rsp.high_peak;
   assign rsp_chan.total_peak = rsp.total_peak;

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !rsp_chan.valid)
      else $error("response right after request accept");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while response pending");
   a_empty_zero_event: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == STS_EMPTY |->
         rsp_chan.ev_payload == '0 && rsp_chan.ev_node == '0 &&
         rsp_chan.ev_queue == '0)
      else $error("event fields not zero on empty status");

endmodule

@@ test/two_level_priority_event_queue_tb.sv @@
// Testbench for the two-level priority event queue: directed and random requests vs. a predictor.
`timescale 1ns / 1ps

module two_level_priority_event_queue_tb;
   import tpq_pkg::*;

   localparam int HI_PTR_W = $clog2(DEF_HI_DEPTH);
   localparam int LO_PTR_W = $clog2(DEF_LOW_DEPTH);
   localparam logic [CSR_ADDR_W-1:0] QNUM_ADDR = {CSR_IDX_QNUM, 2'b00};
   localparam int IDLE_PCT = 28;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tpq_req_if req_ch ();
   tpq_rsp_if rsp_ch ();

   two_level_priority_event_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_ch),
      .rsp_chan    (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   ev_item_type           hi_ring [DEF_HI_DEPTH];
   ev_item_type           lo_ring [DEF_LOW_DEPTH];
   logic [HI_PTR_W-1:0]   hi_head, hi_tail;
   logic [LO_PTR_W-1:0]   lo_head, lo_tail;
   logic [FILL_W-1:0]     hi_peak;
   logic [TOTAL_W-1:0]    all_peak;
   logic [QUEUE_W-1:0]    queue_num;

   rsp_item_type expected_rsps [$];

   bit steady;
   int hold_len;
   int n_errors, n_sent, n_checked, n_full, n_empty, n_bad, n_qnum_writes;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      n_errors++;
      $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
   endtask

   function automatic void reset_predictor();
      hi_head   = '0;
      hi_tail   = '0;
      lo_head   = '0;
      lo_tail   = '0;
      hi_peak   = '0;
      all_peak  = '0;
      queue_num = '0;
   endfunction

   function automatic void raise_peaks();
      logic [FILL_W-1:0]  h;
      logic [TOTAL_W-1:0] t;
      h = FILL_W'(HI_PTR_W'(hi_head - hi_tail));
      t = TOTAL_W'(h) + TOTAL_W'(LO_PTR_W'(lo_head - lo_tail));
      if (h > hi_peak) hi_peak = h;
      if (t > all_peak) all_peak = t;
   endfunction

   function automatic rsp_item_type queue_step(input req_item_type it);
      rsp_item_type r;
      ev_item_type  ev;
      r = '0;
      ev = '{node: it.node_id, etype: it.etype, owned: it.owned,
             ident: it.ident, queue: queue_num, payload: it.payload};
      case (it.req_type)
         REQ_SEND: begin
            if (it.etype > ETYPE_MAX) begin
               r.status = STS_BAD;
            end else if (it.priority_req) begin
               if (HI_PTR_W'(hi_head + 1'b1) == hi_tail) begin
                  r.status = STS_FULL;
               end else begin
                  hi_ring[hi_head] = ev;
                  hi_head = HI_PTR_W'(hi_head + 1'b1);
                  raise_peaks();
               end
            end else begin
               if (LO_PTR_W'(lo_head + 1'b1) == lo_tail) begin
                  r.status = STS_FULL;
               end else begin
                  lo_ring[lo_head] = ev;
                  lo_head = LO_PTR_W'(lo_head + 1'b1);
                  raise_peaks();
               end
            end
         end
         REQ_POP, REQ_PEEK: begin
            if (hi_head != hi_tail) begin
               r.ev = hi_ring[hi_tail];
               if (it.req_type == REQ_POP) hi_tail = HI_PTR_W'(hi_tail + 1'b1);
            end else if (lo_head != lo_tail) begin
               r.ev = lo_ring[lo_tail];
               if (it.req_type == REQ_POP) lo_tail = LO_PTR_W'(lo_tail + 1'b1);
            end else begin
               r.status = STS_EMPTY;
            end
         end
         REQ_CLEAR: begin
            hi_head = '0;
            hi_tail = '0;
            lo_head = '0;
            lo_tail = '0;
         end
         REQ_STATS: begin
            hi_peak  = '0;
            all_peak = '0;
         end
         default: ;
      endcase
      r.high_fill  = FILL_W'(HI_PTR_W'(hi_head - hi_tail));
      r.low_fill   = FILL_W'(LO_PTR_W'(lo_head - lo_tail));
      r.high_peak  = hi_peak;
      r.total_peak = all_peak;
      return r;
   endfunction

   function automatic req_item_type mk_item(input logic [REQ_W-1:0] rq, input logic pr,
                                            input logic [NODE_W-1:0] nd,
                                            input logic [ETYPE_W-1:0] et, input logic ow,
                                            input logic [IDENT_W-1:0] id,
                                            input logic [PAYLOAD_W-1:0] pl);
      return '{req_type: rq, priority_req: pr, node_id: nd, etype: et,
               owned: ow, ident: id, payload: pl};
   endfunction

   function automatic req_item_type ctl_item(input logic [REQ_W-1:0] rq);
      return mk_item(rq, 1'b0, '0, '0, 1'b0, '0, '0);
   endfunction

   function automatic req_item_type good_send(input logic pr);
      return mk_item(REQ_SEND, pr, NODE_W'($urandom), ETYPE_W'($urandom_range(ETYPE_MAX)),
                     1'($urandom), IDENT_W'($urandom), {$urandom, $urandom});
   endfunction

   function automatic req_item_type random_item(input int send_pct);
      req_item_type it;
      int pick;
      it = good_send(1'($urandom));
      if ($urandom_range(99) < 12) it.etype = ETYPE_MAX + ETYPE_W'($urandom_range(4, 1));
      if ($urandom_range(99) >= send_pct) begin
         pick = $urandom_range(99);
         if (pick < 60)      it.req_type = REQ_POP;
         else if (pick < 82) it.req_type = REQ_PEEK;
         else if (pick < 86) it.req_type = REQ_CLEAR;
         else if (pick < 92) it.req_type = REQ_STATS;
         else                it.req_type = REQ_STATS + REQ_W'($urandom_range(3, 1));
      end
      return it;
   endfunction

   task automatic send_item(input req_item_type it);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_ch.req_type     <= it.req_type;
      req_ch.priority_req <= it.priority_req;
      req_ch.node_id      <= it.node_id;
      req_ch.etype        <= it.etype;
      req_ch.owned        <= it.owned;
      req_ch.ident        <= it.ident;
      req_ch.payload      <= it.payload;
      req_ch.valid        <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsps.push_back(queue_step(it));
      n_sent++;
   endtask

   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= QNUM_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // only called with the queue idle
   task automatic set_qnum(input logic [QUEUE_W-1:0] value,
                           input logic [CSR_DATA_W-QUEUE_W-1:0] junk);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, {junk, value}, rd);
      queue_num = value;
      n_qnum_writes++;
      csr_access(1'b0, '0, rd);
      if (rd[QUEUE_W-1:0] !== value)
         report_mismatch("queue number readback", 64'(rd), 64'(value));
   endtask

   // response side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      rsp_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", 64'(rsp_ch.status), '0);
            end else begin
               want = expected_rsps.pop_front();
               n_checked++;
               if (want.status == STS_FULL)  n_full++;
               if (want.status == STS_EMPTY) n_empty++;
               if (want.status == STS_BAD)   n_bad++;
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
               if (rsp_ch.ev_node !== want.ev.node)
                  report_mismatch("ev_node", 64'(rsp_ch.ev_node), 64'(want.ev.node));
               if (rsp_ch.ev_type !== want.ev.etype)
                  report_mismatch("ev_type", 64'(rsp_ch.ev_type), 64'(want.ev.etype));
               if (rsp_ch.ev_owned !== want.ev.owned)
                  report_mismatch("ev_owned", 64'(rsp_ch.ev_owned), 64'(want.ev.owned));
               if (rsp_ch.ev_ident !== want.ev.ident)
                  report_mismatch("ev_ident", 64'(rsp_ch.ev_ident), 64'(want.ev.ident));
               if (rsp_ch.ev_queue !== want.ev.queue)
                  report_mismatch("ev_queue", 64'(rsp_ch.ev_queue), 64'(want.ev.queue));
               if (rsp_ch.ev_payload !== want.ev.payload)
                  report_mismatch("ev_payload", rsp_ch.ev_payload, want.ev.payload);
               if (rsp_ch.high_fill !== want.high_fill)
                  report_mismatch("high_fill", 64'(rsp_ch.high_fill), 64'(want.high_fill));
               if (rsp_ch.low_fill !== want.low_fill)
                  report_mismatch("low_fill", 64'(rsp_ch.low_fill), 64'(want.low_fill));
               if (rsp_ch.high_peak !== want.high_peak)
                  report_mismatch("high_peak", 64'(rsp_ch.high_peak), 64'(want.high_peak));
               if (rsp_ch.total_peak !== want.total_peak)
                  report_mismatch("total_peak", 64'(rsp_ch.total_peak),
                                  64'(want.total_peak));
            end
         end
      end
   end

   task automatic test_directed();
      send_item(ctl_item(REQ_PEEK));
      send_item(ctl_item(REQ_POP));
      send_item(mk_item(REQ_SEND, 1'b1, '1, ETYPE_MAX, 1'b1, '1, '1));
      send_item(mk_item(REQ_SEND, 1'b0, '0, '0, 1'b0, '0, '0));
      send_item(mk_item(REQ_SEND, 1'b0, 16'hAAAA, 3'd2, 1'b0, 16'h5555,
                        64'h5555_AAAA_5555_AAAA));
      for (int et = ETYPE_MAX + 1; et <= 7; et++)
         send_item(mk_item(REQ_SEND, 1'(et), '1, ETYPE_W'(et), 1'b1, '1, '1));
      send_item(ctl_item(REQ_PEEK));
      send_item(ctl_item(REQ_POP));
      send_item(ctl_item(REQ_PEEK));
      send_item(ctl_item(REQ_POP));
      send_item(ctl_item(REQ_POP));
      send_item(ctl_item(REQ_POP));
      for (int rq = REQ_STATS + 1; rq <= 7; rq++)
         send_item(mk_item(REQ_W'(rq), 1'b1, '1, '1, 1'b1, '1, '1));
      send_item(mk_item(REQ_SEND, 1'b1, 16'h1234, 3'd1, 1'b0, 16'h4321, 64'h0123_4567_89AB_CDEF));
      send_item(good_send(1'b0));
      send_item(ctl_item(REQ_CLEAR));
      send_item(ctl_item(REQ_PEEK));
      send_item(ctl_item(REQ_STATS));
      wait_for_responses();
   endtask

   task automatic test_qnum();
      logic [QUEUE_W-1:0] values [3];
      values = '{'1, '0, QUEUE_W'($urandom)};
      foreach (values[i]) begin
         set_qnum(values[i], i == 0 ? '1 : '0);
         send_item(good_send(1'b1));
         send_item(good_send(1'b0));
         send_item(good_send(1'b1));
         send_item(ctl_item(REQ_PEEK));
         repeat (3) send_item(ctl_item(REQ_POP));
         wait_for_responses();
      end
   endtask

   task automatic test_fill_and_drain();
      repeat (DEF_HI_DEPTH - 1) send_item(good_send(1'b1));
      send_item(good_send(1'b1));
      send_item(mk_item(REQ_SEND, 1'b1, '1, ETYPE_MAX + 3'd1, 1'b1, '1, '1));
      repeat (DEF_LOW_DEPTH - 1) send_item(good_send(1'b0));
      send_item(good_send(1'b0));
      send_item(ctl_item(REQ_STATS));
      send_item(ctl_item(REQ_PEEK));
      repeat (DEF_HI_DEPTH + DEF_LOW_DEPTH - 1) send_item(ctl_item(REQ_POP));
      repeat (5) send_item(good_send(1'b0));
      repeat (4) send_item(good_send(1'b1));
      send_item(ctl_item(REQ_CLEAR));
      send_item(ctl_item(REQ_POP));
      wait_for_responses();
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      for (int i = 0; i < 120; i++) send_item(random_item((i / 30) % 2 ? 30 : 70));
      wait_for_responses();
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_len = 300;
      repeat (30) send_item(random_item(60));
      wait_for_responses();
   endtask

   task automatic test_random();
      for (int i = 0; i < 560; i++) begin
         send_item(random_item((i / 40) % 2 ? 30 : 70));
         if (i % 140 == 139) begin
            wait_for_responses();
            set_qnum(QUEUE_W'($urandom), (CSR_DATA_W-QUEUE_W)'($urandom));
         end
      end
      wait_for_responses();
   endtask

   initial begin
      reset              <= 1'b1;
      steady              = 1'b0;
      hold_len            = 0;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_SEND;
      req_ch.priority_req <= 1'b0;
      req_ch.node_id      <= '0;
      req_ch.etype        <= '0;
      req_ch.owned        <= 1'b0;
      req_ch.ident        <= '0;
      req_ch.payload      <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      reset_predictor();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_qnum();
      test_fill_and_drain();
      test_back_to_back();
      test_backpressure();
      test_random();

      wait_for_responses();
      repeat (10) @(posedge clock);
      $display("Ran %0d requests, %0d responses checked, %0d queue number writes.",
               n_sent, n_checked, n_qnum_writes);
      $display("Statuses seen: %0d ring full, %0d both empty, %0d bad type; %0d errors.",
               n_full, n_empty, n_bad, n_errors);
      if (n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
